// ===== rtl/psh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psh_pkg: shared types and constants for the per-square hysteresis classifier
// Board geometry, class codes, register indexes and the classifier result
// struct.
// ----------------------------------------------------------------------------
package psh_pkg;

    localparam int NUM_FILES  = 8;
    localparam int NUM_RANKS  = 8;
    localparam int DEPTH      = NUM_FILES * NUM_RANKS;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int POS_W      = 3;
    localparam int MV_W       = 16;
    localparam int HYST_W     = 15;
    localparam int SUM_W      = MV_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CLS_NEG = 2'd0,
        CLS_POS = 2'd1,
        CLS_NEU = 2'd2,
        CLS_UNK = 2'd3
    } t_class;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS     = 2'd2;

    localparam logic signed [MV_W-1:0] LOW_RESET  = -16'sd100;
    localparam logic signed [MV_W-1:0] HIGH_RESET = 16'sd100;

    typedef struct packed {
        logic   change;
        t_class next;
    } t_cls_result;

endpackage

// ===== rtl/psh_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psh_sample_if: sample request channel
// One offset sample with the file and rank of its square.
// ----------------------------------------------------------------------------
interface psh_sample_if
    import psh_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [POS_W-1:0]       file_index;
    logic [POS_W-1:0]       rank_index;
    logic signed [MV_W-1:0] offset_mv;

    modport source (output valid, output file_index, output rank_index,
                    output offset_mv, input ready);
    modport sink   (input valid, input file_index, input rank_index,
                    input offset_mv, output ready);
endinterface

// ===== rtl/psh_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psh_result_if: class change request channel
// The square whose class changed and its new class.
// ----------------------------------------------------------------------------
interface psh_result_if
    import psh_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] square_file;
    logic [POS_W-1:0] square_rank;
    logic [1:0]       new_class;

    modport source (output valid, output square_file, output square_rank,
                    output new_class, input ready);
    modport sink   (input valid, input square_file, input square_rank,
                    input new_class, output ready);
endinterface

// ===== rtl/per_square_hysteresis_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_square_hysteresis_classifier_core: per-square window comparator
// Keeps a class per board square and reports each class change.
//
//   channel    dir   payload                                 handshake
//   i_sample   in    file_index, rank_index, offset_mv       valid/ready
//   o_result   out   square_file, square_rank, new_class     valid/ready
//   i_cfg_*    in    i_cfg_idx, i_cfg_wdata                  i_cfg_we
//
// One sample per cycle sustained while no result stalls; a request is held in
// stage 1 and then its result in the result register.
// The class of the square is read from the class RAM at accept; a change
// written by the request ahead of it is forwarded into that read.
// Reset clears the per-entry valid bits at once: no clearing pass.
// A stalled result holds the stage behind it; samples keep flowing otherwise.
// ----------------------------------------------------------------------------
module per_square_hysteresis_classifier_core
    import psh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    psh_sample_if.sink            i_sample,
    psh_result_if.source          o_result
);
    // configuration
    logic signed [MV_W-1:0] r_low;
    logic signed [MV_W-1:0] r_high;
    logic [HYST_W-1:0]      r_hyst;

    // class RAM and valid bits
    logic [1:0]             r_mem [DEPTH];
    logic [DEPTH-1:0]       r_vld;

    // stage 1
    logic                   r_s1_valid;
    logic                   r_s1_on;
    logic [POS_W-1:0]       r_s1_file;
    logic [POS_W-1:0]       r_s1_rank;
    logic [IDX_W-1:0]       r_s1_idx;
    logic signed [MV_W-1:0] r_s1_mv;
    logic [1:0]             r_rd_class;
    logic                   r_rd_vld;
    logic                   r_fwd_hit;
    t_class                 r_fwd_class;

    // result register
    logic                   r_out_valid;
    logic [POS_W-1:0]       r_out_file;
    logic [POS_W-1:0]       r_out_rank;
    t_class                 r_out_class;

    logic                   in_acc;
    logic                   in_on;
    logic [IDX_W-1:0]       in_idx;
    logic                   s1_adv;
    logic                   wr_en;
    t_class                 cur_class;
    t_cls_result            cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= LOW_RESET;
            r_high <= HIGH_RESET;
            r_hyst <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOW_THRESHOLD:  r_low  <= $signed(i_cfg_wdata[MV_W-1:0]);
                REG_HIGH_THRESHOLD: r_high <= $signed(i_cfg_wdata[MV_W-1:0]);
                REG_HYSTERESIS:     r_hyst <= i_cfg_wdata[HYST_W-1:0];
                default: ;
            endcase
        end
    end

    assign s1_adv          = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready  = !r_s1_valid || s1_adv;
    assign in_acc          = i_sample.valid && i_sample.ready;
    assign in_on           = (32'(i_sample.file_index) < NUM_FILES)
                          && (32'(i_sample.rank_index) < NUM_RANKS);
    assign in_idx          = IDX_W'(32'(i_sample.file_index) * NUM_RANKS
                                    + 32'(i_sample.rank_index));

    always_comb begin
        if (r_fwd_hit) begin
            cur_class = r_fwd_class;
        end else if (r_rd_vld) begin
            cur_class = t_class'(r_rd_class);
        end else begin
            cur_class = CLS_UNK;
        end
    end

    psh_window u_window (
        .i_cur  (cur_class),
        .i_mv   (r_s1_mv),
        .i_low  (r_low),
        .i_high (r_high),
        .i_hyst (r_hyst),
        .o_res  (cls)
    );

    assign wr_en = s1_adv && r_s1_on && cls.change;

    // class RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s1_idx] <= cls.next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_class <= r_mem[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_s1_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // hold the stage payload while stalled
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_on     <= in_on;
            r_s1_file   <= i_sample.file_index;
            r_s1_rank   <= i_sample.rank_index;
            r_s1_idx    <= in_idx;
            r_s1_mv     <= i_sample.offset_mv;
            r_rd_vld    <= r_vld[in_idx];
            r_fwd_hit   <= wr_en && (r_s1_idx == in_idx);
            r_fwd_class <= cls.next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_on && cls.change;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_out_file  <= r_s1_file;
            r_out_rank  <= r_s1_rank;
            r_out_class <= cls.next;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.square_file = r_out_file;
    assign o_result.square_rank = r_out_rank;
    assign o_result.new_class   = r_out_class;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_idx) && $stable(r_s1_mv))
        else $error("stage 1 request lost or changed while stalled");

    a_change_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> cls.next != cur_class && cls.next != CLS_UNK)
        else $error("class write without a real change");

    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.new_class != CLS_UNK)
        else $error("result reports the unknown class");

    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sample.ready |-> r_s1_valid && r_out_valid && !o_result.ready)
        else $error("sample stalled while the pipeline can move");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_s1_valid)
        else $error("pipeline not empty after reset");

endmodule

// ===== rtl/psh_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psh_window: hysteresis window compare for one square
// Shifts the thresholds by the current class, compares the sample and picks
// the new class with priority above, below, within.
// ----------------------------------------------------------------------------
module psh_window
    import psh_pkg::*;
(
    input  t_class                 i_cur,
    input  logic signed [MV_W-1:0] i_mv,
    input  logic signed [MV_W-1:0] i_low,
    input  logic signed [MV_W-1:0] i_high,
    input  logic [HYST_W-1:0]      i_hyst,
    output t_cls_result            o_res
);
    logic signed [SUM_W-1:0] hyst_e;
    logic signed [SUM_W-1:0] low_e;
    logic signed [SUM_W-1:0] high_e;
    logic signed [SUM_W-1:0] mv_e;
    logic signed [SUM_W-1:0] lo_s;
    logic signed [SUM_W-1:0] hi_s;
    logic                    above;
    logic                    below;
    logic                    in_win;

    assign hyst_e = $signed({{(SUM_W-HYST_W){1'b0}}, i_hyst});
    assign low_e  = SUM_W'(i_low);
    assign high_e = SUM_W'(i_high);
    assign mv_e   = SUM_W'(i_mv);

    always_comb begin
        case (i_cur)
            CLS_POS: begin
                lo_s = low_e - hyst_e;
                hi_s = high_e - hyst_e;
            end
            CLS_NEG: begin
                lo_s = low_e + hyst_e;
                hi_s = high_e + hyst_e;
            end
            CLS_NEU: begin
                lo_s = low_e - hyst_e;
                hi_s = high_e + hyst_e;
            end
            default: begin
                lo_s = low_e;
                hi_s = high_e;
            end
        endcase
    end

    assign above  = mv_e > hi_s;
    assign below  = mv_e < lo_s;
    assign in_win = !above && !below;

    always_comb begin
        o_res.change = 1'b1;
        if (i_cur != CLS_POS && above) begin
            o_res.next = CLS_POS;
        end else if (i_cur != CLS_NEG && below) begin
            o_res.next = CLS_NEG;
        end else if (i_cur != CLS_NEU && in_win) begin
            o_res.next = CLS_NEU;
        end else begin
            o_res.change = 1'b0;
            o_res.next   = i_cur;
        end
    end

endmodule
